@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL file that carries checks, life_grid_engine.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define LGE_ASSERT(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("life grid engine assertion failed");

`define LGE_ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) \
        else $error("life grid engine forbidden condition seen");

`else

`define LGE_ASSERT(lbl, clk_sig, rstn_sig, prop)

`define LGE_ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr)

`endif

`endif

@@ hdl/lge_pkg.sv @@
`default_nettype none

package lge_pkg;

    localparam int LANES      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'h0001;

    typedef enum logic [2:0] {
        OP_STEP      = 3'd0,
        OP_SET_CELL  = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_RANDOMIZE = 3'd3,
        OP_READ_CELL = 3'd4
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RUNNING = 2'd0,
        REG_ROWS    = 2'd1,
        REG_COLS    = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ hdl/life_grid_engine.sv @@
// Life grid engine: Conway's B3/S23 rule on a grid of one-bit cells held in a RAM, one row
// per word. Operations arrive on the input channel (in_valid/in_stall) and each gives
// exactly one result beat on the output channel (out_valid/out_stall). Configuration
// (running, rows_in_use, cols_in_use) is to be written on the cfg channel only while the
// block is idle; the block itself does not enforce it. One operation is worked on at a
// time; in_stall is high from acceptance until the result has been moved to the output
// register. By operation:
//   step (running)  rows are fed from the single RAM read port, one row a cycle, into a
//                   three-row window;
//   randomize       eight cells a cycle from the LFSR fill a row buffer, and each full
//                   row is then written;
//   set, read       the row is read, and for set written back, within the area in use.
// The next operation may be accepted while a result still waits in the output register; it
// then waits at its end until the receiver takes the pending beat. A stalled result holds.
// Reset is immediate: every row valid bit is cleared, so the grid reads as all dead with
// no clearing pass, the generation count is zero and the LFSR holds one.
`default_nettype none

`include "assert_macros.svh"

module life_grid_engine #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [2:0]                       opcode,
    input  wire logic [5:0]                       row,
    input  wire logic [5:0]                       col,
    input  wire logic [15:0]                      seed,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  cell_alive,
    output logic                                  in_range,
    output logic [31:0]                           generation,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lge_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lge_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RAW  = $clog2(GRID_HEIGHT);
    localparam int CAW  = $clog2(GRID_WIDTH);
    localparam int RCW  = $clog2(GRID_HEIGHT + 1);
    localparam int CCW  = $clog2(GRID_WIDTH + 1);
    localparam int RXW  = (RCW > 7) ? RCW : 7;
    localparam int CXXW = (CCW > 7) ? CCW : 7;
    localparam int NCH  = (GRID_WIDTH + lge_pkg::LANES - 1) / lge_pkg::LANES;
    localparam int CHW  = $clog2(NCH + 1);
    localparam int CXW  = $clog2(NCH * lge_pkg::LANES + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_STEP  = 7'b0000100,
        ST_CELL  = 7'b0001000,
        ST_RAND  = 7'b0010000,
        ST_RWR   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                   running_reg;
    logic [6:0]             rows_reg;
    logic [6:0]             cols_reg;

    logic [GRID_HEIGHT-1:0] vld_reg, vld_next;
    logic [31:0]            gen_reg, gen_next;
    logic [15:0]            lfsr_reg, lfsr_next;
    logic [RCW-1:0]         feed_reg, feed_next;
    logic                   feed_active_reg, feed_active_next;
    logic                   arr_valid_reg, arr_valid_next;
    logic                   comp_valid_reg, comp_valid_next;
    logic [CHW-1:0]         chunk_reg, chunk_next;
    logic [RCW-1:0]         rrow_reg, rrow_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;

    lge_pkg::opcode_t       op_reg;
    logic [5:0]             row_reg;
    logic [5:0]             col_reg;
    logic [15:0]            seed_reg;
    logic                   arr_zero_reg;
    logic [RCW-1:0]         arr_idx_reg;
    logic [RCW-1:0]         comp_idx_reg;
    logic [GRID_WIDTH-1:0]  win0_reg;
    logic [GRID_WIDTH-1:0]  win1_reg;
    logic [GRID_WIDTH-1:0]  win2_reg;
    logic [GRID_WIDTH-1:0]  rowbuf_reg;
    logic                   alive_reg;
    logic                   rd_vld_reg;
    logic                   alive_out_reg;
    logic                   inr_out_reg;
    logic [31:0]            gen_out_reg;

    logic [RXW-1:0]         rows_wide;
    logic [CXXW-1:0]        cols_wide;
    logic [RCW-1:0]         eff_rows;
    logic [CCW-1:0]         eff_cols;
    logic                   inr;
    logic [RAW+5:0]         row_wide;
    logic [CAW+5:0]         col_wide;
    logic [RAW-1:0]         row_addr;
    logic [CAW-1:0]         col_addr;
    logic [GRID_WIDTH-1:0]  col_mask;
    logic [GRID_WIDTH-1:0]  rule_row;
    logic [15:0]            seed_fix;

    logic                   ram_we;
    logic [RAW-1:0]         ram_waddr;
    logic [GRID_WIDTH-1:0]  ram_wdata;
    logic                   ram_re;
    logic [RAW-1:0]         ram_raddr;
    logic [GRID_WIDTH-1:0]  ram_rdata;
    logic [GRID_WIDTH-1:0]  rdata_eff;

    logic [15:0]                 lfsr_chain;
    logic [lge_pkg::LANES-1:0]   rnd_bits;
    logic [CXW-1:0]              lane_col;
    logic [GRID_WIDTH-1:0]       rowbuf_fill;

    assign rows_wide = RXW'(rows_reg);
    assign cols_wide = CXXW'(cols_reg);
    assign eff_rows  = (rows_wide > RXW'(GRID_HEIGHT)) ? RCW'(GRID_HEIGHT) : RCW'(rows_wide);
    assign eff_cols  = (cols_wide > CXXW'(GRID_WIDTH)) ? CCW'(GRID_WIDTH) : CCW'(cols_wide);
    assign inr       = (RXW'(row_reg) < RXW'(eff_rows)) && (CXXW'(col_reg) < CXXW'(eff_cols));

    assign row_wide  = {{RAW{1'b0}}, row_reg};
    assign col_wide  = {{CAW{1'b0}}, col_reg};
    assign row_addr  = row_wide[RAW-1:0];
    assign col_addr  = col_wide[CAW-1:0];
    assign seed_fix  = (seed_reg == 16'd0) ? lge_pkg::LFSR_ONE : seed_reg;
    assign rdata_eff = rd_vld_reg ? ram_rdata : '0;

    always_comb
    begin
        for (int c = 0; c < GRID_WIDTH; c++)
        begin
            col_mask[c] = CXW'(c) < CXW'(eff_cols);
        end
    end

    lge_row_rule #(
        .WIDTH (GRID_WIDTH)
    ) u_rule (
        .above    (win0_reg),
        .centre   (win1_reg),
        .below    (win2_reg),
        .col_mask (col_mask),
        .next_row (rule_row)
    );

    lge_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One LFSR step for each cell of the current chunk that lies inside the columns in use, in row-major order.
    always_comb
    begin
        lfsr_chain  = lfsr_reg;
        rnd_bits    = '0;
        lane_col    = '0;
        rowbuf_fill = rowbuf_reg;
        for (int l = 0; l < lge_pkg::LANES; l++)
        begin
            lane_col = CXW'(CXW'(chunk_reg) * CXW'(lge_pkg::LANES)) + CXW'(l);
            if (lane_col < CXW'(eff_cols))
            begin
                rnd_bits[l] = lfsr_chain[0];
                if (lfsr_chain[0])
                begin
                    lfsr_chain = (lfsr_chain >> 1) ^ lge_pkg::LFSR_MASK;
                end
                else
                begin
                    lfsr_chain = lfsr_chain >> 1;
                end
            end
        end
        for (int c = 0; c < GRID_WIDTH; c++)
        begin
            if (CHW'(c / lge_pkg::LANES) == chunk_reg)
            begin
                rowbuf_fill[c] = rnd_bits[c % lge_pkg::LANES];
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            ST_START:
            begin
                if ((op_reg inside {lge_pkg::OP_SET_CELL, lge_pkg::OP_READ_CELL}) && inr)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = row_addr;
                end
            end
            ST_STEP:
            begin
                if (feed_active_reg && (feed_reg < eff_rows))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = feed_reg[RAW-1:0];
                end
                if (comp_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = comp_idx_reg[RAW-1:0];
                    ram_wdata = rule_row;
                end
            end
            ST_CELL:
            begin
                if (op_reg == lge_pkg::OP_SET_CELL)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = row_addr;
                    ram_wdata = rdata_eff | (GRID_WIDTH'(1) << col_addr);
                end
            end
            ST_RWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = rrow_reg[RAW-1:0];
                ram_wdata = rowbuf_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        vld_next         = vld_reg;
        gen_next         = gen_reg;
        lfsr_next        = lfsr_reg;
        feed_next        = feed_reg;
        feed_active_next = feed_active_reg;
        chunk_next       = chunk_reg;
        rrow_next        = rrow_reg;
        out_load         = 1'b0;
        arr_valid_next   = (state_reg == ST_STEP) && feed_active_reg;
        comp_valid_next  = arr_valid_reg && (arr_idx_reg != '0);
        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                case (op_reg)
                    lge_pkg::OP_STEP:
                    begin
                        if (running_reg)
                        begin
                            feed_next        = '0;
                            feed_active_next = 1'b1;
                            state_next       = ST_STEP;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    lge_pkg::OP_SET_CELL, lge_pkg::OP_READ_CELL:
                    begin
                        state_next = inr ? ST_CELL : ST_DONE;
                    end
                    lge_pkg::OP_CLEAR:
                    begin
                        vld_next   = '0;
                        gen_next   = '0;
                        state_next = ST_DONE;
                    end
                    lge_pkg::OP_RANDOMIZE:
                    begin
                        vld_next   = '0;
                        gen_next   = '0;
                        lfsr_next  = seed_fix;
                        chunk_next = '0;
                        rrow_next  = '0;
                        state_next = (eff_rows == '0) ? ST_DONE : ST_RAND;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_STEP:
            begin
                if (feed_active_reg)
                begin
                    if (feed_reg == eff_rows)
                    begin
                        feed_active_next = 1'b0;
                    end
                    else
                    begin
                        feed_next = feed_reg + RCW'(1);
                    end
                end
                else if (!arr_valid_reg && !comp_valid_reg)
                begin
                    gen_next   = gen_reg + 32'd1;
                    state_next = ST_DONE;
                end
            end
            ST_CELL:
            begin
                state_next = ST_DONE;
            end
            ST_RAND:
            begin
                lfsr_next  = lfsr_chain;
                chunk_next = chunk_reg + CHW'(1);
                if (chunk_reg == CHW'(NCH - 1))
                begin
                    state_next = ST_RWR;
                end
            end
            ST_RWR:
            begin
                chunk_next = '0;
                rrow_next  = rrow_reg + RCW'(1);
                state_next = (rrow_next == eff_rows) ? ST_DONE : ST_RAND;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            vld_reg         <= '0;
            gen_reg         <= '0;
            lfsr_reg        <= lge_pkg::LFSR_ONE;
            feed_reg        <= '0;
            feed_active_reg <= 1'b0;
            arr_valid_reg   <= 1'b0;
            comp_valid_reg  <= 1'b0;
            chunk_reg       <= '0;
            rrow_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            vld_reg         <= vld_next;
            gen_reg         <= gen_next;
            lfsr_reg        <= lfsr_next;
            feed_reg        <= feed_next;
            feed_active_reg <= feed_active_next;
            arr_valid_reg   <= arr_valid_next;
            comp_valid_reg  <= comp_valid_next;
            chunk_reg       <= chunk_next;
            rrow_reg        <= rrow_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            rows_reg    <= 7'd64;
            cols_reg    <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lge_pkg::cfg_reg_t'(cfg_index))
                lge_pkg::REG_RUNNING: running_reg <= cfg_data[0];
                lge_pkg::REG_ROWS:    rows_reg    <= cfg_data;
                lge_pkg::REG_COLS:    cols_reg    <= cfg_data;
                default:              running_reg <= running_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg   <= lge_pkg::opcode_t'(opcode);
            row_reg  <= row;
            col_reg  <= col;
            seed_reg <= seed;
        end
        if (ram_re)
        begin
            rd_vld_reg <= vld_reg[ram_raddr];
        end
        arr_zero_reg <= !(feed_reg < eff_rows);
        arr_idx_reg  <= feed_reg;
        comp_idx_reg <= arr_idx_reg - RCW'(1);
        if (state_reg == ST_START)
        begin
            win0_reg   <= '0;
            win1_reg   <= '0;
            win2_reg   <= '0;
            rowbuf_reg <= '0;
            alive_reg  <= 1'b0;
        end
        else
        begin
            if (arr_valid_reg)
            begin
                win0_reg <= win1_reg;
                win1_reg <= win2_reg;
                win2_reg <= arr_zero_reg ? '0 : rdata_eff;
            end
            if (state_reg == ST_RAND)
            begin
                rowbuf_reg <= rowbuf_fill;
            end
            else if (state_reg == ST_RWR)
            begin
                rowbuf_reg <= '0;
            end
            if (state_reg == ST_CELL && op_reg == lge_pkg::OP_READ_CELL)
            begin
                alive_reg <= rdata_eff[col_addr];
            end
        end
        if (out_load)
        begin
            alive_out_reg <= alive_reg;
            inr_out_reg   <= inr;
            gen_out_reg   <= gen_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign cell_alive = alive_out_reg;
    assign in_range   = inr_out_reg;
    assign generation = gen_out_reg;

    `LGE_ASSERT(a_accept_starts, clk, rst_n, in_valid && !in_stall |=> state_reg == ST_START)
    `LGE_ASSERT_NEVER(a_no_rw_same_row, clk, rst_n, ram_we && ram_re && (ram_waddr == ram_raddr))
    `LGE_ASSERT(a_gen_idle_stable, clk, rst_n, state_reg == ST_IDLE |=> $stable(gen_reg))
    `LGE_ASSERT(a_step_row_bound, clk, rst_n, (state_reg == ST_STEP) && ram_we |-> comp_idx_reg < eff_rows)

endmodule

`default_nettype wire

@@ hdl/lge_ram.sv @@
`default_nettype none

module lge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/lge_row_rule.sv @@
`default_nettype none

module lge_row_rule #(
    parameter int WIDTH = 64
) (
    input  wire logic [WIDTH-1:0] above,
    input  wire logic [WIDTH-1:0] centre,
    input  wire logic [WIDTH-1:0] below,
    input  wire logic [WIDTH-1:0] col_mask,
    output logic      [WIDTH-1:0] next_row
);

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    logic [WIDTH+1:0] pad_a;
    logic [WIDTH+1:0] pad_b;
    logic [WIDTH+1:0] pad_c;
    logic [3:0]       cnt;

    always_comb
    begin
        pad_a    = {1'b0, above  & col_mask, 1'b0};
        pad_b    = {1'b0, centre & col_mask, 1'b0};
        pad_c    = {1'b0, below  & col_mask, 1'b0};
        cnt      = '0;
        next_row = '0;
        for (int c = 0; c < WIDTH; c++)
        begin
            cnt = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
                + 4'(pad_b[c]) + 4'(pad_b[c+2])
                + 4'(pad_c[c]) + 4'(pad_c[c+1]) + 4'(pad_c[c+2]);
            if (col_mask[c])
            begin
                next_row[c] = (cnt == BIRTH_COUNT) || (pad_b[c+1] && (cnt == SURVIVE_COUNT));
            end
            else
            begin
                next_row[c] = centre[c];
            end
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int RANDOM_ITEMS = 550;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] OP_UNKNOWN_LAST = 3'd7;

    typedef struct packed {
        logic        alive;
        logic        in_range;
        logic [31:0] generation;
    } cell_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  opcode = '0;
    logic [5:0]  row = '0;
    logic [5:0]  col = '0;
    logic [15:0] seed = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        cell_alive;
    logic        in_range;
    logic [31:0] generation;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [lge_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lge_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [63:0]  life_grid [0:GRID_ROWS-1];
    logic [31:0]  gen_count;
    logic         running_cfg;
    logic [6:0]   rows_cfg;
    logic [6:0]   cols_cfg;

    cell_report_t pending_reports [$];
    int           mismatch_count = 0;
    int           stall_left = 0;
    bit           sender_idles = 1'b1;
    bit           receiver_idles = 1'b1;

    life_grid_engine DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .row        (row),
        .col        (col),
        .seed       (seed),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_alive (cell_alive),
        .in_range   (in_range),
        .generation (generation),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int area_rows();
        return (rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg);
    endfunction

    function automatic int area_cols();
        return (cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg);
    endfunction

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void reset_life_model();
        foreach (life_grid[r])
            life_grid[r] = '0;
        gen_count = '0;
        running_cfg = 1'b0;
        rows_cfg = 7'd64;
        cols_cfg = 7'd64;
    endfunction

    function automatic cell_report_t apply_life_op(logic [2:0] op, logic [5:0] r,
                                                   logic [5:0] c, logic [15:0] s);
        cell_report_t rep;
        logic [63:0]  next_rows [0:GRID_ROWS-1];
        logic [15:0]  lfsr;
        logic         out_bit;
        logic         hit;
        int           nr;
        int           nc;
        int           n;
        int           rr;
        int           cc;
        nr = area_rows();
        nc = area_cols();
        hit = (int'(r) < nr) && (int'(c) < nc);
        rep.alive = 1'b0;
        case (op)
            lge_pkg::OP_STEP:
                if (running_cfg)
                begin
                    next_rows = life_grid;
                    for (int y = 0; y < nr; y++)
                    begin
                        for (int x = 0; x < nc; x++)
                        begin
                            n = 0;
                            for (int dy = -1; dy <= 1; dy++)
                            begin
                                for (int dx = -1; dx <= 1; dx++)
                                begin
                                    rr = y + dy;
                                    cc = x + dx;
                                    if ((dy != 0 || dx != 0) && rr >= 0 && rr < nr
                                        && cc >= 0 && cc < nc)
                                        n += life_grid[rr][cc];
                                end
                            end
                            if (life_grid[y][x])
                                next_rows[y][x] = (n == 2 || n == 3);
                            else
                                next_rows[y][x] = (n == 3);
                        end
                    end
                    life_grid = next_rows;
                    gen_count++;
                end
            lge_pkg::OP_SET_CELL:
                if (hit)
                    life_grid[r][c] = 1'b1;
            lge_pkg::OP_CLEAR:
            begin
                foreach (life_grid[y])
                    life_grid[y] = '0;
                gen_count = '0;
            end
            lge_pkg::OP_RANDOMIZE:
            begin
                lfsr = (s == '0) ? lge_pkg::LFSR_ONE : s;
                foreach (life_grid[y])
                    life_grid[y] = '0;
                for (int y = 0; y < nr; y++)
                begin
                    for (int x = 0; x < nc; x++)
                    begin
                        out_bit = lfsr[0];
                        lfsr = lfsr >> 1;
                        if (out_bit)
                            lfsr = lfsr ^ lge_pkg::LFSR_MASK;
                        life_grid[y][x] = out_bit;
                    end
                end
                gen_count = '0;
            end
            lge_pkg::OP_READ_CELL:
                if (hit)
                    rep.alive = life_grid[r][c];
            default:
                ;
        endcase
        rep.in_range = hit;
        rep.generation = gen_count;
        return rep;
    endfunction

    task automatic send_op(input logic [2:0] op, input logic [5:0] r, input logic [5:0] c,
                           input logic [15:0] s);
        int gap;
        in_valid <= 1'b1;
        opcode <= op;
        row <= r;
        col <= c;
        seed <= s;
        do
            @(posedge clk);
        while (in_stall);
        pending_reports.push_back(apply_life_op(op, r, c, s));
        gap = sender_idles ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input lge_pkg::cfg_reg_t index, input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            lge_pkg::REG_RUNNING: running_cfg = value[0];
            lge_pkg::REG_ROWS:    rows_cfg = value;
            lge_pkg::REG_COLS:    cols_cfg = value;
            default:              ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_area(input logic [6:0] rows_value, input logic [6:0] cols_value);
        write_register(lge_pkg::REG_ROWS, rows_value);
        write_register(lge_pkg::REG_COLS, cols_value);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (receiver_idles && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= gap_length();
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        cell_report_t wanted;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                wanted = pending_reports.pop_front();
                if (cell_alive !== wanted.alive)
                begin
                    $error("cell_alive: expected %0d, got %0d", wanted.alive, cell_alive);
                    mismatch_count++;
                end
                if (in_range !== wanted.in_range)
                begin
                    $error("in_range: expected %0d, got %0d", wanted.in_range, in_range);
                    mismatch_count++;
                end
                if (generation !== wanted.generation)
                begin
                    $error("generation: expected %0d, got %0d", wanted.generation, generation);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        send_op(lge_pkg::OP_READ_CELL, 6'd0, 6'd0, 16'h0000);
        send_op(lge_pkg::OP_READ_CELL, 6'd63, 6'd63, 16'hFFFF);
        send_op(lge_pkg::OP_STEP, 6'd0, 6'd0, 16'h0000);
    endtask

    task automatic test_set_and_read();
        send_op(lge_pkg::OP_SET_CELL, 6'd0, 6'd0, 16'h0000);
        send_op(lge_pkg::OP_SET_CELL, 6'd63, 6'd63, 16'hFFFF);
        send_op(lge_pkg::OP_READ_CELL, 6'd63, 6'd63, 16'h0000);
        send_op(OP_UNKNOWN_FIRST, 6'd63, 6'd63, 16'hFFFF);
        send_op(OP_UNKNOWN_LAST, 6'd0, 6'd0, 16'h0000);
    endtask

    task automatic test_blinker();
        wait_idle();
        write_register(lge_pkg::REG_RUNNING, 7'd1);
        send_op(lge_pkg::OP_SET_CELL, 6'd10, 6'd9, 16'h0000);
        send_op(lge_pkg::OP_SET_CELL, 6'd10, 6'd10, 16'h0000);
        send_op(lge_pkg::OP_SET_CELL, 6'd10, 6'd11, 16'h0000);
        send_op(lge_pkg::OP_STEP, 6'd0, 6'd0, 16'h0000);
        send_op(lge_pkg::OP_READ_CELL, 6'd9, 6'd10, 16'h0000);
        send_op(lge_pkg::OP_STEP, 6'd0, 6'd0, 16'h0000);
        send_op(lge_pkg::OP_READ_CELL, 6'd10, 6'd9, 16'h0000);
    endtask

    task automatic test_randomize_and_clear();
        send_op(lge_pkg::OP_RANDOMIZE, 6'd0, 6'd0, 16'h0000);
        send_op(lge_pkg::OP_STEP, 6'd0, 6'd0, 16'h0000);
        send_op(lge_pkg::OP_RANDOMIZE, 6'd63, 6'd63, 16'hFFFF);
        send_op(lge_pkg::OP_CLEAR, 6'd0, 6'd0, 16'h0000);
    endtask

    task automatic test_area_limits();
        wait_idle();
        set_area(7'd3, 7'd3);
        send_op(lge_pkg::OP_SET_CELL, 6'd3, 6'd1, 16'h0000);
        send_op(lge_pkg::OP_READ_CELL, 6'd3, 6'd1, 16'h0000);
        send_op(lge_pkg::OP_RANDOMIZE, 6'd0, 6'd0, 16'($urandom));
        send_op(lge_pkg::OP_STEP, 6'd0, 6'd0, 16'h0000);
        wait_idle();
        set_area(7'd0, 7'd0);
        send_op(lge_pkg::OP_STEP, 6'd0, 6'd0, 16'h0000);
        send_op(lge_pkg::OP_READ_CELL, 6'd0, 6'd0, 16'h0000);
        wait_idle();
        set_area(7'd127, 7'd65);
        send_op(lge_pkg::OP_READ_CELL, 6'd63, 6'd63, 16'h0000);
        send_op(lge_pkg::OP_STEP, 6'd0, 6'd0, 16'h0000);
    endtask

    function automatic logic [6:0] pick_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return 7'($urandom_range(1, 12));
        else if (pick < 85)
        begin
            case ($urandom_range(0, 2))
                0:       return 7'd0;
                1:       return 7'd1;
                default: return 7'd64;
            endcase
        end
        else
            return 7'($urandom_range(13, 127));
    endfunction

    function automatic logic [5:0] pick_coord(int limit);
        if (limit > 0 && $urandom_range(0, 9) < 8)
            return 6'($urandom_range(0, limit - 1));
        else
            return 6'($urandom_range(0, 63));
    endfunction

    task automatic test_random_phases();
        int          sent;
        int          phase_len;
        int          pick;
        logic [2:0]  op;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Each phase starts from an idle block: the sender first waits for every pending result.
            wait_idle();
            write_register(lge_pkg::REG_RUNNING, 7'($urandom_range(0, 9) < 8));
            set_area(pick_size(), pick_size());
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 60);
            if ($urandom_range(0, 1) == 1)
            begin
                send_op(lge_pkg::OP_RANDOMIZE, 6'($urandom), 6'($urandom), 16'($urandom));
                sent++;
            end
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    op = lge_pkg::OP_STEP;
                else if (pick < 63)
                    op = lge_pkg::OP_SET_CELL;
                else if (pick < 88)
                    op = lge_pkg::OP_READ_CELL;
                else if (pick < 92)
                    op = lge_pkg::OP_CLEAR;
                else if (pick < 96)
                    op = lge_pkg::OP_RANDOMIZE;
                else
                    op = 3'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
                send_op(op, pick_coord(area_rows()), pick_coord(area_cols()), 16'($urandom));
                sent++;
            end
        end
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial
    begin
        reset_life_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_set_and_read();
        test_blinker();
        test_randomize_and_clear();
        test_area_limits();
        test_random_phases();
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
